// File: rtl/lavm_pkg.sv
package lavm_pkg;

   localparam int FRAC_BITS_DEF = 16;

   // row number of the translation row, which closes a matrix
   localparam logic [1:0] ROW_LAST = 2'd3;

   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] eye_x;
      logic signed [31:0] eye_y;
      logic signed [31:0] eye_z;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
      logic signed [31:0] up_x;
      logic signed [31:0] up_y;
      logic signed [31:0] up_z;
   } req_type;

   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [31:0] col0;
      logic signed [31:0] col1;
      logic signed [31:0] col2;
      logic signed [31:0] col3;
      logic               last_row;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] col0;
      logic signed [31:0] col1;
      logic signed [31:0] col2;
      logic signed [31:0] col3;
   } row_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[31:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/lavm_channels.sv
interface lavm_req_if;
   import lavm_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface lavm_rsp_if;
   import lavm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

// File: rtl/lavm_norm.sv
module lavm_norm #(
   parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF,
   parameter int SIDE_W    = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [63:0]          in_vec [3],
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic signed [FRAC_BITS+1:0] out_vec [3],
   output logic [SIDE_W-1:0]           out_side
);

   localparam int SQ_ST    = 16;
   localparam int DV_STEPS = FRAC_BITS + 1;
   localparam int DV_ST    = (FRAC_BITS + 2) / 2;
   localparam int NW       = FRAC_BITS + 32;
   localparam int NT       = SQ_ST + DV_ST + 8;

   // valid, signs, zero flag and side data walk along every stage
   logic [NT-1:0]     vld_ff;
   logic [NT-1:0]     zero_ff;
   logic [2:0]        neg_ff  [NT];
   logic [SIDE_W-1:0] side_ff [NT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff    <= {zero_ff[NT-2:0],
                        (in_vec[0] == 64'sd0) && (in_vec[1] == 64'sd0) && (in_vec[2] == 64'sd0)};
         neg_ff[0]  <= {in_vec[2][63], in_vec[1][63], in_vec[0][63]};
         side_ff[0] <= in_side;
         for (int k = 1; k < NT; k++) begin
            neg_ff[k]  <= neg_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // magnitudes, and their or for the leading one
   logic [63:0] m1_in [3], m1_ff [3];
   logic [63:0] orv1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m1_in[i] = in_vec[i][63] ? unsigned'(-in_vec[i]) : unsigned'(in_vec[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff   <= m1_in;
         orv1_ff <= m1_in[0] | m1_in[1] | m1_in[2];
      end
   end

   // leading one, per byte first
   logic [7:0]  nz2_in, nz2_ff;
   logic [2:0]  lp2_in [8], lp2_ff [8];
   logic [63:0] m2_ff [3];

   always_comb begin
      for (int g = 0; g < 8; g++) begin
         nz2_in[g] = |orv1_ff[8*g +: 8];
         lp2_in[g] = '0;
         for (int b = 0; b < 8; b++) begin
            if (orv1_ff[8*g+b]) begin
               lp2_in[g] = 3'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nz2_ff <= nz2_in;
         lp2_ff <= lp2_in;
         m2_ff  <= m1_ff;
      end
   end

   logic [5:0]  p3_in, p3_ff;
   logic [63:0] m3_ff [3];

   always_comb begin
      p3_in = '0;
      for (int g = 0; g < 8; g++) begin
         if (nz2_ff[g]) begin
            p3_in = {3'(g), lp2_ff[g]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p3_ff <= p3_in;
         m3_ff <= m2_ff;
      end
   end

   // bring the largest magnitude into [2^30, 2^31)
   logic [30:0] sm4_in [3], sm4_ff [3];

   always_comb begin
      logic [63:0] t;
      for (int i = 0; i < 3; i++) begin
         if (p3_ff > 6'd30) begin
            t = m3_ff[i] >> (p3_ff - 6'd30);
         end else begin
            t = m3_ff[i] << (6'd30 - p3_ff);
         end
         sm4_in[i] = t[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sm4_ff <= sm4_in;
      end
   end

   logic [61:0] sq5_ff [3];
   logic [30:0] sm5_ff [3];
   logic [63:0] s6_ff;
   logic [30:0] sm6_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq5_ff[i] <= 62'(sm4_ff[i]) * 62'(sm4_ff[i]);
         end
         sm5_ff <= sm4_ff;
         s6_ff  <= 64'(sq5_ff[0]) + 64'(sq5_ff[1]) + 64'(sq5_ff[2]);
         sm6_ff <= sm5_ff;
      end
   end

   // square root, two result bits per stage
   logic [63:0] sr_ff  [SQ_ST];
   logic [33:0] rm_ff  [SQ_ST];
   logic [31:0] rt_ff  [SQ_ST];
   logic [30:0] smq_ff [SQ_ST][3];

   for (genvar k = 0; k < SQ_ST; k++) begin : g_sq
      logic [63:0] sr_p, sr_n;
      logic [33:0] rm_p, rm_n;
      logic [31:0] rt_p, rt_n;
      logic [30:0] sm_p [3];

      if (k == 0) begin : g_first
         assign sr_p = s6_ff;
         assign rm_p = '0;
         assign rt_p = '0;
         assign sm_p = sm6_ff;
      end else begin : g_next
         assign sr_p = sr_ff[k-1];
         assign rm_p = rm_ff[k-1];
         assign rt_p = rt_ff[k-1];
         assign sm_p = smq_ff[k-1];
      end

      always_comb begin
         logic [35:0] acc;
         logic [35:0] trial;
         sr_n = sr_p;
         rm_n = rm_p;
         rt_n = rt_p;
         for (int t = 0; t < 2; t++) begin
            acc   = {rm_n, sr_n[63:62]};
            trial = {2'b00, rt_n, 2'b01};
            if (acc >= trial) begin
               acc  = acc - trial;
               rt_n = {rt_n[30:0], 1'b1};
            end else begin
               rt_n = {rt_n[30:0], 1'b0};
            end
            rm_n = acc[33:0];
            sr_n = {sr_n[61:0], 2'b00};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sr_ff[k]  <= sr_n;
            rm_ff[k]  <= rm_n;
            rt_ff[k]  <= rt_n;
            smq_ff[k] <= sm_p;
         end
      end
   end

   // rounded quotient: dividend is m << frac plus half the length
   logic [FRAC_BITS:0] nlo_ff [3];
   logic [32:0]        drm_ff [3];
   logic [31:0]        len_ff;

   always_ff @(posedge clock) begin
      logic [NW-1:0] n;
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            n = (NW'(smq_ff[SQ_ST-1][i]) << FRAC_BITS) + NW'(rt_ff[SQ_ST-1][31:1]);
            nlo_ff[i] <= n[FRAC_BITS:0];
            drm_ff[i] <= 33'(n >> (FRAC_BITS + 1));
         end
         len_ff <= rt_ff[SQ_ST-1];
      end
   end

   logic [FRAC_BITS:0] dn_ff [DV_ST][3];
   logic [32:0]        dr_ff [DV_ST][3];
   logic [FRAC_BITS:0] dq_ff [DV_ST][3];
   logic [31:0]        dl_ff [DV_ST];

   for (genvar k = 0; k < DV_ST; k++) begin : g_dv
      logic [FRAC_BITS:0] dn_p [3], dn_n [3];
      logic [32:0]        dr_p [3], dr_n [3];
      logic [FRAC_BITS:0] dq_p [3], dq_n [3];
      logic [31:0]        dl_p;

      if (k == 0) begin : g_first
         assign dn_p = nlo_ff;
         assign dr_p = drm_ff;
         assign dl_p = len_ff;
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               dq_p[i] = '0;
            end
         end
      end else begin : g_next
         assign dn_p = dn_ff[k-1];
         assign dr_p = dr_ff[k-1];
         assign dq_p = dq_ff[k-1];
         assign dl_p = dl_ff[k-1];
      end

      always_comb begin
         logic [33:0] acc;
         for (int i = 0; i < 3; i++) begin
            dn_n[i] = dn_p[i];
            dr_n[i] = dr_p[i];
            dq_n[i] = dq_p[i];
            for (int t = 0; t < 2; t++) begin
               if (2 * k + t < DV_STEPS) begin
                  acc = {dr_n[i], dn_n[i][FRAC_BITS]};
                  if (acc >= {2'b00, dl_p}) begin
                     acc     = acc - {2'b00, dl_p};
                     dq_n[i] = {dq_n[i][FRAC_BITS-1:0], 1'b1};
                  end else begin
                     dq_n[i] = {dq_n[i][FRAC_BITS-1:0], 1'b0};
                  end
                  dr_n[i] = acc[32:0];
                  dn_n[i] = {dn_n[i][FRAC_BITS-1:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dn_ff[k] <= dn_n;
            dr_ff[k] <= dr_n;
            dq_ff[k] <= dq_n;
            dl_ff[k] <= dl_p;
         end
      end
   end

   logic signed [FRAC_BITS+1:0] o_in [3], o_ff [3];

   always_comb begin
      logic signed [FRAC_BITS+1:0] qs;
      for (int i = 0; i < 3; i++) begin
         qs = signed'({1'b0, dq_ff[DV_ST-1][i]});
         if (zero_ff[NT-2]) begin
            o_in[i] = '0;
         end else if (neg_ff[NT-2][i]) begin
            o_in[i] = -qs;
         end else begin
            o_in[i] = qs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_ff <= o_in;
      end
   end

   assign out_valid = vld_ff[NT-1];
   assign out_vec   = o_ff;
   assign out_side  = side_ff[NT-1];

endmodule

// File: rtl/lavm_rows.sv
module lavm_rows (
   input  logic              clock,
   input  logic              reset,
   input  logic              ld_valid,
   input  lavm_pkg::row_type ld_mat [4],
   output logic              ld_ok,
   lavm_rsp_if.source        rsp_if
);
   import lavm_pkg::*;

   logic       full_ff;
   logic [1:0] cnt_ff;
   row_type    mat_ff [4];
   logic       take;

   assign take  = rsp_if.valid && rsp_if.ready;
   // a new matrix may enter as the last row leaves
   assign ld_ok = !full_ff || (take && (cnt_ff == ROW_LAST));

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (ld_ok) begin
         full_ff <= ld_valid;
         cnt_ff  <= '0;
      end else if (take) begin
         cnt_ff <= cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_ok && ld_valid) begin
         mat_ff <= ld_mat;
      end
   end

   assign rsp_if.valid = full_ff;

   always_comb begin
      rsp_if.data.row_index = cnt_ff;
      rsp_if.data.col0      = mat_ff[cnt_ff].col0;
      rsp_if.data.col1      = mat_ff[cnt_ff].col1;
      rsp_if.data.col2      = mat_ff[cnt_ff].col2;
      rsp_if.data.col3      = mat_ff[cnt_ff].col3;
      rsp_if.data.last_row  = (cnt_ff == ROW_LAST);
   end

endmodule

// File: rtl/look_at_view_matrix_unit.sv
// channel  dir  payload                                   handshake
// req_if   in   eye, target, up (x,y,z each Q16.16)       valid/ready, one item per view
// rsp_if   out  row_index, col0..col3, last_row           valid/ready, four items per view
//
// at the result port a view's four rows leave one per cycle while the receiver is ready
// the path to the first row lies mostly in the two normalizers (16 square root stages
// and FRAC_BITS/2+1 divider stages each)
// reset clears the valid bits of all stages and the row buffer
// the pipeline advances whenever its last stage is empty or the row buffer takes it
module look_at_view_matrix_unit #(
   parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lavm_req_if.sink   req_if,
   lavm_rsp_if.source rsp_if
);
   import lavm_pkg::*;

   localparam int ZW = FRAC_BITS + 2;
   localparam int YW = FRAC_BITS + 3;
   localparam int PW = ZW + 32;
   localparam int S1 = 192;
   localparam int S2 = 96 + 3 * ZW;

   logic adv, ld_ok;
   logic a_vld_ff, c1_vld_ff, c2_vld_ff, d1_vld_ff, d2_vld_ff, d3_vld_ff, d4_vld_ff;
   logic fin_vld_ff;
   logic n1_vld, n2_vld;

   assign adv          = !fin_vld_ff || ld_ok;
   assign req_if.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         c1_vld_ff  <= 1'b0;
         c2_vld_ff  <= 1'b0;
         d1_vld_ff  <= 1'b0;
         d2_vld_ff  <= 1'b0;
         d3_vld_ff  <= 1'b0;
         d4_vld_ff  <= 1'b0;
         fin_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff   <= req_if.valid;
         c1_vld_ff  <= n1_vld;
         c2_vld_ff  <= c1_vld_ff;
         d1_vld_ff  <= n2_vld;
         d2_vld_ff  <= d1_vld_ff;
         d3_vld_ff  <= d2_vld_ff;
         d4_vld_ff  <= d3_vld_ff;
         fin_vld_ff <= d4_vld_ff;
      end
   end

   function automatic logic signed [63:0] rshift(input logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? unsigned'(-v) : unsigned'(v);
      m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return v[63] ? -signed'(m) : signed'(m);
   endfunction

   // forward vector
   logic signed [31:0] req_eye [3], req_tgt [3], req_up [3];
   logic signed [32:0] fwd_a_ff [3];
   logic signed [31:0] eye_a_ff [3], up_a_ff [3];

   assign req_eye[0] = req_if.data.eye_x;
   assign req_eye[1] = req_if.data.eye_y;
   assign req_eye[2] = req_if.data.eye_z;
   assign req_tgt[0] = req_if.data.target_x;
   assign req_tgt[1] = req_if.data.target_y;
   assign req_tgt[2] = req_if.data.target_z;
   assign req_up[0]  = req_if.data.up_x;
   assign req_up[1]  = req_if.data.up_y;
   assign req_up[2]  = req_if.data.up_z;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            fwd_a_ff[i] <= 33'(req_tgt[i]) - 33'(req_eye[i]);
         end
         eye_a_ff <= req_eye;
         up_a_ff  <= req_up;
      end
   end

   logic signed [63:0]   n1_in [3];
   logic [S1-1:0]        n1_side_in, n1_side_out;
   logic signed [ZW-1:0] z_n1 [3];
   logic signed [31:0]   eye_n1 [3], up_n1 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n1_in[i] = 64'(fwd_a_ff[i]);
      end
   end

   assign n1_side_in = {eye_a_ff[0], eye_a_ff[1], eye_a_ff[2],
                        up_a_ff[0], up_a_ff[1], up_a_ff[2]};

   lavm_norm #(
      .FRAC_BITS(FRAC_BITS),
      .SIDE_W   (S1)
   ) u_norm_fwd (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (a_vld_ff),
      .in_vec   (n1_in),
      .in_side  (n1_side_in),
      .out_valid(n1_vld),
      .out_vec  (z_n1),
      .out_side (n1_side_out)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         eye_n1[i] = signed'(n1_side_out[S1-1-32*i -: 32]);
         up_n1[i]  = signed'(n1_side_out[95-32*i -: 32]);
      end
   end

   // side axis before normalizing: up x z
   logic signed [PW-1:0] pc1_ff [6];
   logic signed [31:0]   eye_c1_ff [3];
   logic signed [ZW-1:0] z_c1_ff [3];
   logic signed [63:0]   xr_c2_ff [3];
   logic signed [31:0]   eye_c2_ff [3];
   logic signed [ZW-1:0] z_c2_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         pc1_ff[0] <= up_n1[1] * z_n1[2];
         pc1_ff[1] <= up_n1[2] * z_n1[1];
         pc1_ff[2] <= up_n1[2] * z_n1[0];
         pc1_ff[3] <= up_n1[0] * z_n1[2];
         pc1_ff[4] <= up_n1[0] * z_n1[1];
         pc1_ff[5] <= up_n1[1] * z_n1[0];
         eye_c1_ff <= eye_n1;
         z_c1_ff   <= z_n1;
         for (int i = 0; i < 3; i++) begin
            xr_c2_ff[i] <= 64'(pc1_ff[2*i]) - 64'(pc1_ff[2*i+1]);
         end
         eye_c2_ff <= eye_c1_ff;
         z_c2_ff   <= z_c1_ff;
      end
   end

   logic [S2-1:0]        n2_side_in, n2_side_out;
   logic signed [ZW-1:0] x_n2 [3], z_n2 [3];
   logic signed [31:0]   eye_n2 [3];

   assign n2_side_in = {eye_c2_ff[0], eye_c2_ff[1], eye_c2_ff[2],
                        z_c2_ff[0], z_c2_ff[1], z_c2_ff[2]};

   lavm_norm #(
      .FRAC_BITS(FRAC_BITS),
      .SIDE_W   (S2)
   ) u_norm_side (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (c2_vld_ff),
      .in_vec   (xr_c2_ff),
      .in_side  (n2_side_in),
      .out_valid(n2_vld),
      .out_vec  (x_n2),
      .out_side (n2_side_out)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         eye_n2[i] = signed'(n2_side_out[S2-1-32*i -: 32]);
         z_n2[i]   = signed'(n2_side_out[3*ZW-1-ZW*i -: ZW]);
      end
   end

   // z x x products and dot products with the eye
   logic signed [2*ZW-1:0] yp_d1_ff [6];
   logic signed [PW-1:0]   dx_d1_ff [3], dz_d1_ff [3];
   logic signed [ZW-1:0]   x_d1_ff [3], z_d1_ff [3];
   logic signed [31:0]     eye_d1_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         yp_d1_ff[0] <= z_n2[1] * x_n2[2];
         yp_d1_ff[1] <= z_n2[2] * x_n2[1];
         yp_d1_ff[2] <= z_n2[2] * x_n2[0];
         yp_d1_ff[3] <= z_n2[0] * x_n2[2];
         yp_d1_ff[4] <= z_n2[0] * x_n2[1];
         yp_d1_ff[5] <= z_n2[1] * x_n2[0];
         for (int i = 0; i < 3; i++) begin
            dx_d1_ff[i] <= x_n2[i] * eye_n2[i];
            dz_d1_ff[i] <= z_n2[i] * eye_n2[i];
         end
         x_d1_ff   <= x_n2;
         z_d1_ff   <= z_n2;
         eye_d1_ff <= eye_n2;
      end
   end

   logic signed [63:0]   yr_d2_ff [3];
   logic signed [63:0]   dx_d2_ff, dz_d2_ff;
   logic signed [ZW-1:0] x_d2_ff [3], z_d2_ff [3];
   logic signed [31:0]   eye_d2_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            yr_d2_ff[i] <= 64'(yp_d1_ff[2*i]) - 64'(yp_d1_ff[2*i+1]);
         end
         dx_d2_ff  <= 64'(dx_d1_ff[0]) + 64'(dx_d1_ff[1]) + 64'(dx_d1_ff[2]);
         dz_d2_ff  <= 64'(dz_d1_ff[0]) + 64'(dz_d1_ff[1]) + 64'(dz_d1_ff[2]);
         x_d2_ff   <= x_d1_ff;
         z_d2_ff   <= z_d1_ff;
         eye_d2_ff <= eye_d1_ff;
      end
   end

   logic signed [YW-1:0] y_d3_ff [3];
   logic signed [31:0]   ndx_d3_ff, ndz_d3_ff;
   logic signed [ZW-1:0] x_d3_ff [3], z_d3_ff [3];
   logic signed [31:0]   eye_d3_ff [3];

   always_ff @(posedge clock) begin
      logic signed [63:0] t;
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            t = rshift(yr_d2_ff[i]);
            y_d3_ff[i] <= t[YW-1:0];
         end
         ndx_d3_ff <= sat32(-rshift(dx_d2_ff));
         ndz_d3_ff <= sat32(-rshift(dz_d2_ff));
         x_d3_ff   <= x_d2_ff;
         z_d3_ff   <= z_d2_ff;
         eye_d3_ff <= eye_d2_ff;
      end
   end

   logic signed [YW+31:0] py_d4_ff [3];
   logic signed [YW-1:0]  y_d4_ff [3];
   logic signed [31:0]    ndx_d4_ff, ndz_d4_ff;
   logic signed [ZW-1:0]  x_d4_ff [3], z_d4_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            py_d4_ff[i] <= y_d3_ff[i] * eye_d3_ff[i];
         end
         y_d4_ff   <= y_d3_ff;
         ndx_d4_ff <= ndx_d3_ff;
         ndz_d4_ff <= ndz_d3_ff;
         x_d4_ff   <= x_d3_ff;
         z_d4_ff   <= z_d3_ff;
      end
   end

   row_type fin_mat_in [4], fin_mat_ff [4];

   always_comb begin
      logic signed [63:0] sy;
      sy = 64'(py_d4_ff[0]) + 64'(py_d4_ff[1]) + 64'(py_d4_ff[2]);
      for (int r = 0; r < 3; r++) begin
         fin_mat_in[r].col0 = sat32(64'(x_d4_ff[r]));
         fin_mat_in[r].col1 = sat32(64'(y_d4_ff[r]));
         fin_mat_in[r].col2 = sat32(64'(z_d4_ff[r]));
         fin_mat_in[r].col3 = '0;
      end
      fin_mat_in[3].col0 = ndx_d4_ff;
      fin_mat_in[3].col1 = sat32(-rshift(sy));
      fin_mat_in[3].col2 = ndz_d4_ff;
      fin_mat_in[3].col3 = sat32(64'sd1 <<< FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_mat_ff <= fin_mat_in;
      end
   end

   lavm_rows u_rows (
      .clock   (clock),
      .reset   (reset),
      .ld_valid(fin_vld_ff),
      .ld_mat  (fin_mat_ff),
      .ld_ok   (ld_ok),
      .rsp_if  (rsp_if)
   );

endmodule

// File: rtl/lavm_checker.sv
module lavm_checker #(
   parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input lavm_pkg::rsp_type rsp_data
);
   import lavm_pkg::*;

   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_rows_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_row
      |=> rsp_valid && (rsp_data.row_index == $past(rsp_data.row_index) + 2'd1))
      else $error("matrix rows not delivered in order");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.last_row == (rsp_data.row_index == ROW_LAST))
      else $error("last_row flag does not match row index");

   a_col3_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.row_index != ROW_LAST) |-> rsp_data.col3 == 32'sd0)
      else $error("axis row has nonzero fourth column");

   a_col3_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.row_index == ROW_LAST) |-> rsp_data.col3 == ONE)
      else $error("translation row fourth column is not one");

endmodule

bind look_at_view_matrix_unit lavm_checker #(.FRAC_BITS(FRAC_BITS)) u_lavm_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .rsp_data (rsp_if.data)
);

// File: dv/tb_top.sv
module tb_top;
   import lavm_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam int DRAIN_CYCLES = 2 * (FRAC / 2) + 120;

   typedef longint vec_type [3];

   logic clock = 1'b0;
   logic reset = 1'b1;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_request = 0;

   lavm_req_if req_if();
   lavm_rsp_if rsp_if();

   look_at_view_matrix_unit dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if.sink),
      .rsp_if(rsp_if.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- view matrix predictor ----------------

   function automatic longint round_fix(longint v);
      bit [63:0] m;
      m = v < 0 ? -v : v;
      m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic bit [63:0] int_sqrt(bit [63:0] s);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= res + b) begin
            s = s - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic vec_type unit_vec(vec_type v);
      bit [63:0] m [3];
      bit [63:0] mx, s, len, q;
      vec_type o;
      mx = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = v[i] < 0 ? -v[i] : v[i];
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         o = '{0, 0, 0};
         return o;
      end
      while (mx >= (64'd1 << 31)) begin
         mx = mx >> 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (mx < (64'd1 << 30)) begin
         mx = mx << 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
      len = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << FRAC) + (len >> 1)) / len;
         o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return o;
   endfunction

   function automatic vec_type cross_vec(vec_type a, vec_type b);
      vec_type o;
      o[0] = a[1] * b[2] - a[2] * b[1];
      o[1] = a[2] * b[0] - a[0] * b[2];
      o[2] = a[0] * b[1] - a[1] * b[0];
      return o;
   endfunction

   function automatic logic signed [31:0] translation(vec_type a, vec_type e);
      return clamp32(-round_fix(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]));
   endfunction

   class view_scoreboard;
      rsp_type rows_due[$];
      int errors = 0;
      int views = 0;
      int rows_seen = 0;

      function void note_view(req_type d);
         vec_type eye, fwd, zax, xax, yax;
         rsp_type r;
         eye = '{d.eye_x, d.eye_y, d.eye_z};
         fwd = '{longint'(d.target_x) - eye[0], longint'(d.target_y) - eye[1],
                 longint'(d.target_z) - eye[2]};
         zax = unit_vec(fwd);
         xax = unit_vec(cross_vec('{d.up_x, d.up_y, d.up_z}, zax));
         yax = cross_vec(zax, xax);
         for (int i = 0; i < 3; i++) yax[i] = round_fix(yax[i]);
         for (int i = 0; i < 3; i++) begin
            r.row_index = 2'(i);
            r.col0 = clamp32(xax[i]);
            r.col1 = clamp32(yax[i]);
            r.col2 = clamp32(zax[i]);
            r.col3 = '0;
            r.last_row = 1'b0;
            rows_due.push_back(r);
         end
         r.row_index = ROW_LAST;
         r.col0 = translation(xax, eye);
         r.col1 = translation(yax, eye);
         r.col2 = translation(zax, eye);
         r.col3 = clamp32(longint'(1) << FRAC);
         r.last_row = 1'b1;
         rows_due.push_back(r);
         views++;
      endfunction

      function void field(string name, longint want, longint got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_row(rsp_type got);
         rsp_type want;
         rows_seen++;
         if (rows_due.size() == 0) begin
            $error("row with no view pending: row_index %0d", got.row_index);
            errors++;
            return;
         end
         want = rows_due.pop_front();
         field("row_index", want.row_index, got.row_index);
         field("col0", want.col0, got.col0);
         field("col1", want.col1, got.col1);
         field("col2", want.col2, got.col2);
         field("col3", want.col3, got.col3);
         field("last_row", want.last_row, got.last_row);
      endfunction
   endclass

   view_scoreboard views_sb = new();

   // ---------------- stimulus ----------------

   task automatic send_view(req_type d);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= d;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      views_sb.note_view(d);
   endtask

   function automatic logic signed [31:0] near_coord();
      return $signed($urandom_range(32'h00ffffff)) - 32'sh00800000;
   endfunction

   function automatic req_type random_view();
      req_type d;
      int kind;
      logic signed [31:0] k;
      kind = $urandom_range(9);
      d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
      if (kind < 5) begin
         // scene-sized coordinates
         d.eye_x = near_coord(); d.eye_y = near_coord(); d.eye_z = near_coord();
         d.target_x = near_coord(); d.target_y = near_coord(); d.target_z = near_coord();
         d.up_x = near_coord(); d.up_y = near_coord(); d.up_z = near_coord();
      end else if (kind == 6) begin
         d.target_x = d.eye_x; d.target_y = d.eye_y; d.target_z = d.eye_z;
      end else if (kind == 7) begin
         // up along the line of sight
         d.eye_x = near_coord(); d.eye_y = near_coord(); d.eye_z = near_coord();
         d.target_x = near_coord(); d.target_y = near_coord(); d.target_z = near_coord();
         k = $signed($urandom_range(6)) - 3;
         d.up_x = k * (d.target_x - d.eye_x);
         d.up_y = k * (d.target_y - d.eye_y);
         d.up_z = k * (d.target_z - d.eye_z);
      end else if (kind == 8) begin
         d.up_x = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         d.eye_z = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         d.target_z = -d.eye_z;
      end
      return d;
   endfunction

   function automatic req_type make_view(int ex, int ey, int ez, int tx, int ty, int tz,
                                         int ux, int uy, int uz);
      req_type d;
      d = {ex, ey, ez, tx, ty, tz, ux, uy, uz};
      return d;
   endfunction

   task automatic run_phase(int n, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (n) send_view(random_view());
   endtask

   // result side, with the long hold-off counted here
   int hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) views_sb.check_row(rsp_if.data);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   localparam int ONE = 32'h00010000;
   localparam int MAXV = 32'h7fffffff;
   localparam int MINV = 32'h80000000;

   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed views
      send_view(make_view(0, 0, -5 * ONE, 0, 0, 0, 0, ONE, 0));
      send_view(make_view(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0));
      send_view(make_view(0, 0, 0, 0, 3 * ONE, 0, 0, ONE, 0));
      send_view(make_view(0, 0, 0, 0, 0, ONE, 0, 0, -7 * ONE));
      send_view(make_view(0, 0, 0, ONE, 0, 0, 0, 0, 0));
      send_view(make_view(MAXV, MAXV, MAXV, MINV, MINV, MINV, 0, ONE, 0));
      send_view(make_view(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, MAXV));
      send_view(make_view(MAXV, MINV, 0, MINV, MAXV, 1, MINV, MINV, MINV));
      send_view(make_view(MINV, 0, MINV, MINV, 0, MAXV, ONE, 0, 0));
      send_view(make_view(MAXV, MAXV, 0, MAXV, MAXV, 1, 0, ONE, 0));
      send_view(make_view(-1, -1, -1, 0, 0, 0, MAXV, 0, MINV));
      send_view(make_view(0, 0, 0, 1, 1, 1, -1, 1, -1));
      send_view(make_view(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
      send_view(make_view(MAXV, 0, 0, MAXV - 1, 0, 0, 0, MAXV, 0));
      send_view(make_view(0, 0, 0, MAXV, MAXV, MAXV, MINV, MAXV, 0));

      run_phase(60, 0, 0);
      run_phase(60, 45, 0);
      hold_request = 400;
      run_phase(60, 0, 45);
      run_phase(60, 14, 14);
      req_if.valid <= 1'b0;

      while (views_sb.rows_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d views, %0d matrix rows, with directed corner views",
               views_sb.views, views_sb.rows_seen);
      $display("and random views under sender idling, receiver stalls and a long hold-off");
      if (views_sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
